FILE: hw/rtl/keyframe_lerp_evaluator_core_assert.svh
// ----------------------------------------------------------------------------
// Keyframe evaluator assertion macros
// Concurrent checks that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_LERP_EVALUATOR_CORE_ASSERT_SVH
`define KEYFRAME_LERP_EVALUATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define KLE_ASSERT(lbl, clk_i, rst_n_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) \
		else $error("keyframe evaluator check failed");
`define KLE_ASSERT_ALWAYS(lbl, clk_i, prop) \
	lbl: assert property (@(posedge clk_i) prop) \
		else $error("keyframe evaluator check failed");
`else
`define KLE_ASSERT(lbl, clk_i, rst_n_i, prop)
`define KLE_ASSERT_ALWAYS(lbl, clk_i, prop)
`endif
`endif

FILE: hw/rtl/klerp_pkg.sv
// ----------------------------------------------------------------------------
// klerp_pkg
// Shared types, constants and helpers of the keyframe evaluator.
// ----------------------------------------------------------------------------
package klerp_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int FRAC_BITS = 16;
	localparam int ADDR_W    = $clog2(MAX_KEYS);
	localparam int CNT_W     = $clog2(MAX_KEYS + 1);
	localparam int DT_W      = 33;
	localparam int NUM_W     = DT_W + FRAC_BITS;
	localparam int PROD_W    = DT_W + 32;
	localparam int N_CH      = 7;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_EVAL   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_UPD   = 2'd0,
		STAT_NOUPD = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_ACK   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LAST_RD, ST_LAST_CHK, ST_SRCH_RD, ST_SRCH_CHK,
		ST_A_RD, ST_A_CAP, ST_B_RD, ST_B_CAP, ST_DIV, ST_MUL, ST_ACC, ST_DONE
	} state_t;

	// val: 0 scale x, 1 scale y, 2..4 rot x/y/z, 5 pos x, 6 pos y
	typedef struct packed {
		logic [31:0]           ktime;
		logic [N_CH-1:0][31:0] val;
		logic [7:0]            tex;
	} key_t;

	// clamp a wide signed sum to the 32-bit range
	function automatic logic [31:0] sat32(input logic signed [PROD_W:0] v);
		logic signed [PROD_W:0] hi;
		logic signed [PROD_W:0] lo;
		hi = (PROD_W + 1)'(64'sh7FFF_FFFF);
		lo = -(PROD_W + 1)'(64'sh8000_0000);
		if (v > hi) return 32'h7FFF_FFFF;
		else if (v < lo) return 32'h8000_0000;
		else return v[31:0];
	endfunction

endpackage

FILE: hw/rtl/klerp_key_mem.sv
// ----------------------------------------------------------------------------
// klerp_key_mem
// Keyframe table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module klerp_key_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [klerp_pkg::ADDR_W-1:0] waddr,
	input  klerp_pkg::key_t           wdata,
	input  logic [klerp_pkg::ADDR_W-1:0] raddr,
	output klerp_pkg::key_t           rdata
);
	import klerp_pkg::*;

	key_t mem [MAX_KEYS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/klerp_div.sv
// ----------------------------------------------------------------------------
// klerp_div
// Bit-serial signed divider for the interpolation fraction, one quotient
// bit per cycle, result clamped to +-2^30.
// ----------------------------------------------------------------------------
module klerp_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [klerp_pkg::NUM_W-1:0] num,
	input  logic signed [klerp_pkg::DT_W-1:0]  den,
	output logic                             done,
	output logic signed [31:0]               frac
);
	import klerp_pkg::*;

	localparam int STEP_W = $clog2(NUM_W + 1);
	localparam logic [NUM_W-1:0] LIM = NUM_W'(1) << 30;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DT_W-1:0]   rem_q;
	logic [DT_W-1:0]   dvs_q;
	logic              neg_q;
	logic [DT_W:0]     rem_sh;
	logic              ge;
	logic [31:0]       mag;

	// one restoring step
	always_comb begin
		rem_sh = {rem_q, quo_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			dvs_q <= den[DT_W-1] ? DT_W'(-den) : DT_W'(den);
			neg_q <= num[NUM_W-1] ^ den[DT_W-1];
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DT_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	// clamp and sign
	always_comb begin
		mag  = (quo_q > LIM) ? LIM[31:0] : quo_q[31:0];
		frac = neg_q ? -$signed(mag) : $signed(mag);
	end

	assign done = done_q;

endmodule

FILE: hw/rtl/keyframe_lerp_evaluator_core.sv
// ----------------------------------------------------------------------------
// keyframe_lerp_evaluator_core
// Linear keyframe interpolation for one track over a keyframe table.
//
//  channel | signals                       | dir | content
//  in      | in_valid/in_ready + fields    | in  | command, time, key values
//  out     | out_valid/out_ready + fields  | out | status, transform, flags
//  cfg     | cfg_valid/cfg_ready, cfg_data | in  | repeat_stops_play
//
// Clear, append, unknown command and evaluate on an empty table go straight to
// the finish. An in-range evaluate scans keys from the end through the table read
// port, reads the pair around the time, divides for the fraction and interpolates.
// One item at a time; reset empties the table and zeroes held values.
// A waiting result stalls only the finish of the next item.
// ----------------------------------------------------------------------------
`include "keyframe_lerp_evaluator_core_assert.svh"

module keyframe_lerp_evaluator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] time_value,
	input  logic               playing,
	input  logic signed [31:0] scale_x,
	input  logic signed [31:0] scale_y,
	input  logic signed [31:0] rot_x,
	input  logic signed [31:0] rot_y,
	input  logic signed [31:0] rot_z,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [7:0]         tex_frame,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] out_scale_x,
	output logic signed [31:0] out_scale_y,
	output logic signed [31:0] out_rot_x,
	output logic signed [31:0] out_rot_y,
	output logic signed [31:0] out_rot_z,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic [7:0]         out_tex_frame,
	output logic               time_wrapped,
	output logic               stop_play
);
	import klerp_pkg::*;

	state_t state_q, state_d;

	logic                    cfg_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [31:0]      t_q;
	logic                    play_q;
	status_t                 stat_q;
	logic                    wrap_q, stop_q;
	logic [ADDR_W-1:0]       j_q, idx_q;
	logic [2:0]              k_q;
	key_t                    a_q, b_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic [31:0]             held_q [N_CH];
	logic [7:0]              htex_q;
	logic                    out_valid_q;

	// table port
	logic              we;
	key_t              wkey;
	logic [ADDR_W-1:0] raddr;
	key_t              rkey;

	// control
	logic accept, out_load, div_start, div_done;
	logic signed [31:0] frac;

	// datapath helpers
	logic signed [31:0]      last_t, key_t_rd;
	logic                    wrap_c, in_rng, hit, has_next;
	logic signed [31:0]      t_eff;
	logic signed [DT_W-1:0]  dt_c, dnum_c;
	logic signed [NUM_W-1:0] num_c;
	logic signed [DT_W-1:0]  diff_c;
	logic signed [PROD_W:0]  sum_c;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign we        = accept && (cmd_t'(cmd) == CMD_APPEND) && (cnt_q < CNT_W'(MAX_KEYS));
	assign wkey      = '{ktime: time_value,
		val: {pos_y, pos_x, rot_z, rot_y, rot_x, scale_y, scale_x}, tex: tex_frame};

	klerp_key_mem u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(wkey),
		.raddr(raddr),
		.rdata(rkey)
	);

	klerp_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_c),
		.den   (dt_c),
		.done  (div_done),
		.frac  (frac)
	);

	// wrap, range, search and interpolation arithmetic
	always_comb begin
		key_t_rd = $signed(rkey.ktime);
		last_t   = key_t_rd;
		wrap_c   = play_q && (t_q > last_t);
		t_eff    = wrap_c ? 32'sd0 : t_q;
		in_rng   = (t_eff >= 32'sd0) && (t_eff <= last_t);
		hit      = key_t_rd <= t_q;
		has_next = ({1'b0, idx_q} + CNT_W'(1)) < cnt_q;
		dt_c     = $signed({rkey.ktime[31], rkey.ktime}) - $signed({a_q.ktime[31], a_q.ktime});
		dnum_c   = $signed({t_q[31], t_q}) - $signed({a_q.ktime[31], a_q.ktime});
		num_c    = {dnum_c, {FRAC_BITS{1'b0}}};
		diff_c   = $signed({b_q.val[k_q][31], b_q.val[k_q]})
			- $signed({a_q.val[k_q][31], a_q.val[k_q]});
		sum_c    = (PROD_W + 1)'($signed(a_q.val[k_q]))
			+ (PROD_W + 1)'(prod_s1 >>> FRAC_BITS);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd_t'(cmd) == CMD_EVAL && cnt_q != '0) state_d = ST_LAST_RD;
					else state_d = ST_DONE;
				end
			end
			ST_LAST_RD:  state_d = ST_LAST_CHK;
			ST_LAST_CHK: state_d = in_rng ? ST_SRCH_RD : ST_DONE;
			ST_SRCH_RD:  state_d = ST_SRCH_CHK;
			ST_SRCH_CHK: state_d = (hit || j_q == '0) ? ST_A_RD : ST_SRCH_RD;
			ST_A_RD:     state_d = ST_A_CAP;
			ST_A_CAP:    state_d = has_next ? ST_B_RD : ST_DONE;
			ST_B_RD:     state_d = ST_B_CAP;
			ST_B_CAP:    state_d = (dt_c == '0) ? ST_DONE : ST_DIV;
			ST_DIV:      state_d = div_done ? ST_MUL : ST_DIV;
			ST_MUL:      state_d = ST_ACC;
			ST_ACC:      state_d = (k_q == 3'(N_CH - 1)) ? ST_DONE : ST_MUL;
			ST_DONE:     state_d = out_load ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		raddr     = '0;
		unique case (state_q)
			ST_IDLE:     in_ready = 1'b1;
			ST_LAST_RD:  raddr = ADDR_W'(cnt_q - CNT_W'(1));
			ST_SRCH_RD:  raddr = j_q;
			ST_A_RD:     raddr = idx_q;
			ST_B_RD:     raddr = idx_q + ADDR_W'(1);
			ST_B_CAP:    div_start = (dt_c != '0);
			ST_DONE:     out_load = !out_valid_q || out_ready;
			default:     raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 1'b0;
		end else if (cfg_valid) begin
			cfg_q <= cfg_data;
		end
	end

	// table fill count and held transform
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			htex_q <= '0;
			for (int i = 0; i < N_CH; i++) held_q[i] <= '0;
		end else begin
			if (accept && cmd_t'(cmd) == CMD_CLEAR) cnt_q <= '0;
			if (we) cnt_q <= cnt_q + CNT_W'(1);
			if (state_q == ST_A_CAP) begin
				htex_q <= rkey.tex;
				if (!has_next) begin
					held_q[0] <= rkey.val[0];
					held_q[1] <= rkey.val[1];
					held_q[5] <= rkey.val[5];
					held_q[6] <= rkey.val[6];
				end
			end
			if (state_q == ST_B_CAP && dt_c == '0) begin
				for (int i = 0; i < N_CH; i++) held_q[i] <= a_q.val[i];
			end
			if (state_q == ST_ACC) held_q[k_q] <= sat32(sum_c);
		end
	end

	// item working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q    <= time_value;
			play_q <= playing;
			wrap_q <= 1'b0;
			stop_q <= 1'b0;
			unique case (cmd_t'(cmd))
				CMD_CLEAR:  stat_q <= STAT_ACK;
				CMD_APPEND: stat_q <= (cnt_q < CNT_W'(MAX_KEYS)) ? STAT_ACK : STAT_FULL;
				default:    stat_q <= STAT_NOUPD;
			endcase
		end
		unique case (state_q)
			ST_LAST_CHK: begin
				wrap_q <= wrap_c;
				stop_q <= wrap_c && cfg_q;
				t_q    <= t_eff;
				j_q    <= ADDR_W'(cnt_q - CNT_W'(1));
			end
			ST_SRCH_CHK: begin
				idx_q <= j_q;
				j_q   <= j_q - ADDR_W'(1);
			end
			ST_A_CAP: begin
				a_q    <= rkey;
				stat_q <= STAT_UPD;
			end
			ST_B_CAP: begin
				b_q <= rkey;
				k_q <= '0;
			end
			ST_MUL:  prod_s1 <= diff_c * frac;
			ST_ACC:  k_q <= k_q + 3'd1;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status        <= stat_q;
			out_scale_x   <= held_q[0];
			out_scale_y   <= held_q[1];
			out_rot_x     <= held_q[2];
			out_rot_y     <= held_q[3];
			out_rot_z     <= held_q[4];
			out_pos_x     <= held_q[5];
			out_pos_y     <= held_q[6];
			out_tex_frame <= htex_q;
			time_wrapped  <= wrap_q;
			stop_play     <= stop_q;
		end
	end

	assign out_valid = out_valid_q;

	`KLE_ASSERT(a_cnt_max, clk, arst_n, cnt_q <= CNT_W'(MAX_KEYS))
	`KLE_ASSERT(a_out_from_done, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_DONE))
	`KLE_ASSERT(a_div_in_div, clk, arst_n, div_done |-> state_q == ST_DIV)
	`KLE_ASSERT(a_stop_needs_wrap, clk, arst_n, out_valid_q && stop_play |-> time_wrapped)

endmodule
